/* hdl/short_word_set_macros.svh */
// ----------------------------------------------------------------------------
// Short word set assertion macros
// Property templates used by the controller to check its own logic.
// ----------------------------------------------------------------------------
`ifndef SHORT_WORD_SET_MACROS_SVH
`define SHORT_WORD_SET_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/sws_pkg.sv */
// ----------------------------------------------------------------------------
// Short word set package
// Field widths, operation codes, controller states and shared structs.
// ----------------------------------------------------------------------------
package sws_pkg;

    localparam int WORD_W       = 56;
    localparam int LEN_W        = 4;
    localparam int ACT_W        = 2;
    localparam int CNT_OUT_W    = 5;
    localparam int MAX_WORD_LEN = 8;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_CLEAR  = 2'd3
    } act_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MV_RD,
        ST_MV_WR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [WORD_W-1:0] wdata;
    } mem_cmd_t;

    typedef struct packed {
        logic                 is_empty;
        logic                 is_full;
        logic [CNT_OUT_W-1:0] entry_count;
        logic                 ok;
    } result_t;

    // Bytes after the first zero byte do not belong to the word.
    function automatic logic [WORD_W-1:0] canonical_word(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] r;
        logic              keep;
        r    = '0;
        keep = 1'b1;
        for (int b = 0; b < WORD_W / 8; b++) begin
            keep = keep && (w[8*b +: 8] != 8'h00);
            if (keep) begin
                r[8*b +: 8] = w[8*b +: 8];
            end
        end
        return r;
    endfunction

endpackage

/* hdl/sws_mem.sv */
// ----------------------------------------------------------------------------
// Short word set store
// Single-port synchronous memory with a registered read port.
// ----------------------------------------------------------------------------
module sws_mem
    import sws_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              aclk,
    input  mem_cmd_t          cmd,
    input  logic [AW-1:0]     addr,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (cmd.en) begin
            if (cmd.we) begin
                mem[addr] <= cmd.wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/sws_ctrl.sv */
// ----------------------------------------------------------------------------
// Short word set controller
// Scans the store for a word, appends on insert, and closes the gap on remove.
// ----------------------------------------------------------------------------
`include "short_word_set_macros.svh"

module sws_ctrl
    import sws_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int CW       = 5,
    parameter int AW       = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  act_t              s_act,
    input  logic [WORD_W-1:0] s_word,
    input  logic [LEN_W-1:0]  s_len,
    output logic              m_tvalid,
    input  logic              m_tready,
    output result_t           m_res,
    output mem_cmd_t          mem_cmd,
    output logic [AW-1:0]     mem_addr,
    input  logic [WORD_W-1:0] mem_rdata
);

    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    state_t            state_reg, state_next;
    act_t              act_reg, act_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     pend_idx_reg, pend_idx_next;
    logic              pend_reg, pend_next;
    logic              ok_reg, ok_next;
    logic              m_tvalid_reg, m_tvalid_next;
    result_t           res_reg, res_next;

    logic              hit;
    logic [CW:0]       idx_inc;
    logic [CW+4:0]     count_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg      <= act_next;
        word_reg     <= word_next;
        idx_reg      <= idx_next;
        pend_idx_reg <= pend_idx_next;
        ok_reg       <= ok_next;
        res_reg      <= res_next;
    end

    assign hit       = pend_reg && (mem_rdata == word_reg);
    assign idx_inc   = {1'b0, idx_reg} + {{CW{1'b0}}, 1'b1};
    assign count_ext = {5'b0, count_reg};

    always_comb begin
        state_next    = state_reg;
        act_next      = act_reg;
        word_next     = word_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        pend_idx_next = pend_idx_reg;
        pend_next     = 1'b0;
        ok_next       = ok_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        res_next      = res_reg;
        mem_cmd       = '{en: 1'b0, we: 1'b0, wdata: word_reg};
        mem_addr      = idx_reg[AW-1:0];
        s_tready      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    act_next  = s_act;
                    word_next = canonical_word(s_word);
                    idx_next  = '0;
                    case (s_act)
                        ACT_CLEAR: begin
                            count_next = '0;
                            ok_next    = 1'b1;
                            state_next = ST_DONE;
                        end
                        ACT_INSERT: begin
                            if (count_reg >= CAP_C || s_len >= LEN_W'(MAX_WORD_LEN)) begin
                                ok_next    = 1'b0;
                                state_next = ST_DONE;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        default: begin
                            state_next = ST_SCAN;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    case (act_reg)
                        ACT_REMOVE: begin
                            idx_next   = pend_idx_reg;
                            state_next = ST_MV_RD;
                        end
                        ACT_LOOKUP: begin
                            ok_next    = 1'b1;
                            state_next = ST_DONE;
                        end
                        default: begin
                            ok_next    = 1'b0;
                            state_next = ST_DONE;
                        end
                    endcase
                end else if (idx_reg < count_reg) begin
                    mem_cmd.en    = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg;
                    idx_next      = idx_inc[CW-1:0];
                end else if (!pend_reg) begin
                    state_next = ST_DONE;
                    if (act_reg == ACT_INSERT) begin
                        mem_cmd.en = 1'b1;
                        mem_cmd.we = 1'b1;
                        mem_addr   = count_reg[AW-1:0];
                        count_next = count_reg + {{(CW-1){1'b0}}, 1'b1};
                        ok_next    = 1'b1;
                    end else begin
                        ok_next    = 1'b0;
                    end
                end
            end
            ST_MV_RD: begin
                if (idx_inc < {1'b0, count_reg}) begin
                    mem_cmd.en = 1'b1;
                    mem_addr   = idx_inc[AW-1:0];
                    state_next = ST_MV_WR;
                end else begin
                    count_next = count_reg - {{(CW-1){1'b0}}, 1'b1};
                    ok_next    = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_MV_WR: begin
                mem_cmd.en    = 1'b1;
                mem_cmd.we    = 1'b1;
                mem_cmd.wdata = mem_rdata;
                idx_next      = idx_inc[CW-1:0];
                state_next    = ST_MV_RD;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next        = 1'b1;
                    res_next.ok          = ok_reg;
                    res_next.entry_count = count_ext[CNT_OUT_W-1:0];
                    res_next.is_full     = (count_reg == CAP_C);
                    res_next.is_empty    = (count_reg == '0);
                    state_next           = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_res    = res_reg;

    `SWS_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CAP_C, "count above capacity")
    `SWS_ASSERT_SAME(a_write_place, aclk, aresetn, mem_cmd.en && mem_cmd.we, (state_reg == ST_MV_WR && idx_reg < count_reg) || (state_reg == ST_SCAN && act_reg == ACT_INSERT && count_reg < CAP_C), "store written outside append or move")
    `SWS_ASSERT_NEXT(a_leave_idle, aclk, aresetn, s_tvalid && s_tready, state_reg != ST_IDLE, "accepted transfer left the controller idle")

endmodule

/* hdl/short_word_set.sv */
// ----------------------------------------------------------------------------
// Short word set
// Bounded set of distinct words of up to seven bytes with insert, remove,
// lookup and clear; each transfer in gives one status transfer out.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_        in         tuser: action; tdata: word, word_length
// m_        out        tdata: ok, entry_count, is_full, is_empty
//
// Insert and lookup scan the single-port store word by word for a match; a
// rejected insert or a clear goes straight to the result without a scan. Remove
// stops its scan at the match, then reads each later word and writes it back one
// place lower to close the gap, each move passing through ST_MV_RD and ST_MV_WR.
// One transfer is in flight at a time; a pending result does not block the
// next input transfer. Reset clears the count; the store needs no clearing.
// ----------------------------------------------------------------------------
module short_word_set
    import sws_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // action
    input  logic [63:0] s_tdata,   // word[55:0], word_length[59:56], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // ok[0], entry_count[5:1], is_full[6], is_empty[7]
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    mem_cmd_t          mem_cmd;
    logic [AW-1:0]     mem_addr;
    logic [WORD_W-1:0] mem_rdata;
    result_t           res;

    sws_ctrl #(
        .CAPACITY (CAPACITY),
        .CW       (CW),
        .AW       (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_act     (act_t'(s_tuser)),
        .s_word    (s_tdata[WORD_W-1:0]),
        .s_len     (s_tdata[WORD_W +: LEN_W]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_res     (res),
        .mem_cmd   (mem_cmd),
        .mem_addr  (mem_addr),
        .mem_rdata (mem_rdata)
    );

    sws_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .cmd   (mem_cmd),
        .addr  (mem_addr),
        .rdata (mem_rdata)
    );

    assign m_tdata = {res.is_empty, res.is_full, res.entry_count, res.ok};

endmodule
